// ===== rtl/psf_pkg.sv =====
// Shared types and constants of the power-of-two weighted smoothing filter.
// Holds the payload structs, the job descriptor and the back-end state codes.
// No dependencies.
package psf_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int TAPS_LIMIT  = 15;
  localparam int CNT_W       = $clog2(TAPS_LIMIT + 1);
  localparam int HALF_W      = 3;

  localparam logic [HALF_W-1:0] HALF_RESET = 3'd2;

  typedef logic [HALF_W-1:0] half_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          frame_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] smoothed;
    logic                          run_end;
    logic                          frame_done;
    logic                          too_short;
  } out_item_t;

  typedef struct packed {
    logic             raw;
    logic             frame_end;
    half_t            half;
    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] first_age;
    logic [CNT_W-1:0] count;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ACC,
    B_START,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

// ===== rtl/pow2_weighted_smoothing_filter.sv =====
// Top level of the power-of-two weighted smoothing filter.
// Depends on psf_pkg, psf_front, psf_queue and psf_back.
//
// A sample is accepted while the two-entry job queue has room; a sample
// that produces results queues one job. The back end produces the results
// of a job one at a time: a raw result of a short frame goes straight to the
// output state, while a smoothed result accumulates its taps, starts the
// divider, waits until the divider reports completion and then goes to the
// output state. Each job passes through the idle state before its first
// result, and a result not yet popped holds the back end. The pace of
// results is set by the shared tap accumulator and the bit-serial divider
// in the back end. The half span register is latched at the first sample
// of each frame.
module pow2_weighted_smoothing_filter #(
  parameter int MAX_TAPS = 11
) (
  input  logic               clk,
  input  logic               rst_n,
  input  psf_pkg::in_item_t  in_item,
  input  logic               push,
  output logic               full,
  output psf_pkg::out_item_t out_item,
  output logic               empty,
  input  logic               pop,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  psf_pkg::half_t     cfg_data
);
  import psf_pkg::*;

  logic                                 q_full;
  logic                                 q_empty;
  logic                                 enq;
  logic                                 deq;
  job_t                                 enq_job;
  job_t                                 head_job;
  logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0] enq_win;
  logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0] head_win;

  psf_front #(
    .MAX_TAPS(MAX_TAPS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .push     (push),
    .full     (full),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .enq      (enq),
    .job      (enq_job),
    .win      (enq_win)
  );

  psf_queue #(
    .MAX_TAPS(MAX_TAPS)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .enq     (enq),
    .enq_job (enq_job),
    .enq_win (enq_win),
    .deq     (deq),
    .q_full  (q_full),
    .q_empty (q_empty),
    .head_job(head_job),
    .head_win(head_win)
  );

  psf_back #(
    .MAX_TAPS(MAX_TAPS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .job     (head_job),
    .win     (head_win),
    .deq     (deq),
    .pop     (pop),
    .empty   (empty),
    .out_item(out_item)
  );

  a_no_enq_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    enq |-> !q_full)
    else $error("Job queued while the job queue is full.");

  a_no_deq_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    deq |-> !q_empty)
    else $error("Job retired while the job queue is empty.");

  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.frame_done) |-> out_item.run_end)
    else $error("Frame done flagged on a result that does not end its run.");

endmodule

// ===== rtl/psf_front.sv =====
// Front end: accepts samples, keeps the sample window, frame fill and span,
// and queues a job for each sample that has results. Depends on psf_pkg.
module psf_front #(
  parameter int MAX_TAPS = 11
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  psf_pkg::in_item_t                            in_item,
  input  logic                                         push,
  output logic                                         full,
  input  logic                                         cfg_valid,
  output logic                                         cfg_ready,
  input  psf_pkg::half_t                               cfg_data,
  input  logic                                         q_full,
  output logic                                         enq,
  output psf_pkg::job_t                                job,
  output logic [MAX_TAPS-1:0][psf_pkg::SAMPLE_BITS-1:0] win
);
  import psf_pkg::*;

  localparam int MAX_HALF = (MAX_TAPS - 1) / 2;

  half_t                             cfg_half_r;
  half_t                             span_r;
  logic [CNT_W-1:0]                  fill_r;
  logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0] win_r;
  logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0] win_nxt;

  logic             accept;
  logic             has_job;
  half_t            h;
  logic [CNT_W-1:0] taps;
  logic [CNT_W-1:0] fill_new;
  logic             was_full;

  assign accept    = push && !q_full;
  assign full      = q_full;
  assign cfg_ready = 1'b1;
  assign win_nxt   = {win_r[MAX_TAPS-2:0], in_item.sample};
  assign win       = win_nxt;
  assign enq       = accept && has_job;

  always_comb begin
    if (fill_r != '0) begin
      h = span_r;
    end else if (cfg_half_r == '0) begin
      h = HALF_W'(1);
    end else if (cfg_half_r > HALF_W'(MAX_HALF)) begin
      h = HALF_W'(MAX_HALF);
    end else begin
      h = cfg_half_r;
    end
    taps     = CNT_W'({h, 1'b0}) + CNT_W'(1);
    was_full = fill_r >= taps;
    fill_new = was_full ? fill_r : fill_r + CNT_W'(1);

    job.raw       = 1'b0;
    job.frame_end = in_item.frame_end;
    job.half      = h;
    job.fill      = fill_new;
    job.first_age = CNT_W'(h);
    job.count     = CNT_W'(1);
    has_job       = 1'b0;
    if (!in_item.frame_end) begin
      if (was_full) begin
        has_job = 1'b1;
      end else if (fill_new == taps) begin
        has_job       = 1'b1;
        job.first_age = taps - CNT_W'(1);
        job.count     = CNT_W'(h) + CNT_W'(1);
      end
    end else begin
      has_job = 1'b1;
      if (fill_new < taps) begin
        job.raw       = 1'b1;
        job.first_age = fill_new - CNT_W'(1);
        job.count     = fill_new;
      end else if (!was_full) begin
        job.first_age = taps - CNT_W'(1);
        job.count     = taps;
      end else begin
        job.count = CNT_W'(h) + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_half_r <= HALF_RESET;
      span_r     <= HALF_W'(1);
      fill_r     <= '0;
    end else begin
      if (cfg_valid) begin
        cfg_half_r <= cfg_data;
      end
      if (accept) begin
        span_r <= h;
        fill_r <= in_item.frame_end ? '0 : fill_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

endmodule

// ===== rtl/psf_queue.sv =====
// Two-entry job queue between front and back end; each entry carries a job
// descriptor and a snapshot of the sample window. Depends on psf_pkg.
module psf_queue #(
  parameter int MAX_TAPS = 11
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          enq,
  input  psf_pkg::job_t                                 enq_job,
  input  logic [MAX_TAPS-1:0][psf_pkg::SAMPLE_BITS-1:0] enq_win,
  input  logic                                          deq,
  output logic                                          q_full,
  output logic                                          q_empty,
  output psf_pkg::job_t                                 head_job,
  output logic [MAX_TAPS-1:0][psf_pkg::SAMPLE_BITS-1:0] head_win
);
  import psf_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  job_t                                 job_r [DEPTH];
  logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0] win_r [DEPTH];
  logic [PTR_W-1:0]                     wr_ptr_r;
  logic [PTR_W-1:0]                     rd_ptr_r;
  logic [PTR_W:0]                       cnt_r;

  assign q_full   = cnt_r == (PTR_W + 1)'(DEPTH);
  assign q_empty  = cnt_r == '0;
  assign head_job = job_r[rd_ptr_r];
  assign head_win = win_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (enq) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (deq) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (enq && !deq) begin
        cnt_r <= cnt_r + (PTR_W + 1)'(1);
      end else if (deq && !enq) begin
        cnt_r <= cnt_r - (PTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      job_r[wr_ptr_r] <= enq_job;
      win_r[wr_ptr_r] <= enq_win;
    end
  end

endmodule

// ===== rtl/psf_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Used by the back end for the rounded weighted average. No dependencies.
module psf_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};
  assign done   = done_r;
  assign quo    = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
      cnt_r <= CW'(NUM_W);
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      quo_r <= {quo_r[NUM_W-2:0], fits};
      rem_r <= fits ? DEN_W'(rem_sh - {1'b0, den_r}) : DEN_W'(rem_sh);
      cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

// ===== rtl/psf_back.sv =====
// Back end: runs each job result by result, passing a raw result straight
// through or accumulating the weighted taps and dividing through psf_div,
// and holds the output register. Depends on psf_pkg and psf_div.
module psf_back #(
  parameter int MAX_TAPS = 11
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          q_empty,
  input  psf_pkg::job_t                                 job,
  input  logic [MAX_TAPS-1:0][psf_pkg::SAMPLE_BITS-1:0] win,
  output logic                                          deq,
  input  logic                                          pop,
  output logic                                          empty,
  output psf_pkg::out_item_t                            out_item
);
  import psf_pkg::*;

  localparam int MAX_HALF = (MAX_TAPS - 1) / 2;
  localparam int SUMW     = SAMPLE_BITS + MAX_HALF + 3;
  localparam int WSW      = MAX_HALF + 3;
  localparam int NUM_W    = SUMW + 1;
  localparam int DEN_W    = WSW + 1;
  localparam int AIDX_W   = $clog2(MAX_TAPS);

  back_state_t              state_r, state_nxt;
  logic [CNT_W-1:0]         k_r, k_nxt;
  logic [AIDX_W-1:0]        age_r, age_nxt;
  logic [CNT_W-1:0]         t_r, t_nxt;
  logic signed [SUMW-1:0]   sum_r, sum_nxt;
  logic [WSW-1:0]           wsum_r, wsum_nxt;
  logic [SAMPLE_BITS-1:0]   res_r, res_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_item_r, out_item_nxt;

  logic                     slot_free;
  logic                     last_t;
  logic                     last_k;
  logic [CNT_W:0]           pos;
  logic [CNT_W:0]           src;
  logic                     incl;
  logic [CNT_W-1:0]         tap_off;
  half_t                    shift;
  logic signed [SUMW-1:0]   term;
  logic [WSW-1:0]           wterm;
  logic [SUMW-1:0]          mag;
  logic [SAMPLE_BITS-1:0]   q_low;
  logic                     div_start;
  logic                     div_done;
  logic [NUM_W-1:0]         div_num;
  logic [DEN_W-1:0]         div_den;
  logic [NUM_W-1:0]         div_quo;

  assign slot_free = !out_valid_r || pop;
  assign last_t    = t_r == CNT_W'({job.half, 1'b0});
  assign last_k    = k_r == job.count - CNT_W'(1);
  assign empty     = !out_valid_r;
  assign out_item  = out_item_r;

  // The tap at window age age+h-t is used when it lies inside the frame.
  always_comb begin
    pos     = (CNT_W + 1)'(age_r) + (CNT_W + 1)'(job.half);
    src     = pos - (CNT_W + 1)'(t_r);
    incl    = (pos >= (CNT_W + 1)'(t_r)) && (src < (CNT_W + 1)'(job.fill));
    tap_off = (t_r < CNT_W'(job.half)) ? CNT_W'(job.half) - t_r : t_r - CNT_W'(job.half);
    shift   = HALF_W'(CNT_W'(job.half) - tap_off);
    term  = '0;
    wterm = '0;
    if (incl) begin
      term  = SUMW'(signed'(win[src[AIDX_W-1:0]])) <<< shift;
      wterm = WSW'(1) << shift;
    end
    mag     = sum_r[SUMW-1] ? SUMW'(-sum_r) : SUMW'(sum_r);
    div_num = {mag, 1'b0} + NUM_W'(wsum_r);
    div_den = {wsum_r, 1'b0};
    q_low   = div_quo[SAMPLE_BITS-1:0];
  end

  psf_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          state_nxt = job.raw ? B_OUT : B_ACC;
        end
      end
      B_ACC: begin
        if (last_t) begin
          state_nxt = B_START;
        end
      end
      B_START: state_nxt = B_DIV;
      B_DIV: begin
        if (div_done) begin
          state_nxt = B_OUT;
        end
      end
      B_OUT: begin
        if (slot_free) begin
          if (last_k) begin
            state_nxt = B_IDLE;
          end else begin
            state_nxt = job.raw ? B_OUT : B_ACC;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    k_nxt        = k_r;
    age_nxt      = age_r;
    t_nxt        = t_r;
    sum_nxt      = sum_r;
    wsum_nxt     = wsum_r;
    res_nxt      = res_r;
    out_item_nxt = out_item_r;
    div_start    = 1'b0;
    deq          = 1'b0;
    out_valid_nxt = pop ? 1'b0 : out_valid_r;
    case (state_r)
      B_IDLE: begin
        k_nxt    = '0;
        age_nxt  = job.first_age[AIDX_W-1:0];
        t_nxt    = '0;
        sum_nxt  = '0;
        wsum_nxt = '0;
      end
      B_ACC: begin
        t_nxt    = t_r + CNT_W'(1);
        sum_nxt  = sum_r + term;
        wsum_nxt = wsum_r + wterm;
      end
      B_START: div_start = 1'b1;
      B_DIV: begin
        if (div_done) begin
          res_nxt = sum_r[SUMW-1] ? -q_low : q_low;
        end
      end
      B_OUT: begin
        if (slot_free) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.smoothed   = job.raw ? win[age_r] : res_r;
          out_item_nxt.run_end    = last_k;
          out_item_nxt.frame_done = last_k && job.frame_end;
          out_item_nxt.too_short  = job.raw;
          if (last_k) begin
            deq = 1'b1;
          end else begin
            k_nxt    = k_r + CNT_W'(1);
            age_nxt  = age_r - AIDX_W'(1);
            t_nxt    = '0;
            sum_nxt  = '0;
            wsum_nxt = '0;
          end
        end
      end
      default: begin
        k_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    age_r      <= age_nxt;
    t_r        <= t_nxt;
    sum_r      <= sum_nxt;
    wsum_r     <= wsum_nxt;
    res_r      <= res_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule
